// ===== hw/rtl/date_add_subtract_days_top_defines.svh =====
// Assertion macros for the date add/subtract block.
`ifndef DATE_ADD_SUBTRACT_DAYS_TOP_DEFINES_SVH
`define DATE_ADD_SUBTRACT_DAYS_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, switched off while reset is asserted
`define DAD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define DAD_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DAD_ASSERT(lbl, clk, rst_n, prop, msg)
`define DAD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/dad_pkg.sv =====
// Shared types, constants and month length function for the date add/subtract block.
`default_nettype none
package dad_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int CNT_W   = 16;

	localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
	localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

	// Operation selected by tuser
	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_SUB = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CLAMP,
		ST_WALK,
		ST_DONE
	} dad_state_t;

	// Result of one month step of the walk unit
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [CNT_W-1:0]   count;
		logic               done;
		logic               sat;
	} dad_step_t;

	// Days in a month (1..12) given the leap flag of its year
	function automatic logic [DAY_W-1:0] dad_month_len(input logic [MONTH_W-1:0] month,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (month)
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/date_add_subtract_days_top.sv =====
// Top level of the Gregorian date add/subtract block: sequencer, state and output register.
//
// Takes a date (year, month, day), a day count and a kind (add or subtract) and gives the
// date that lies that many days later or earlier. Out-of-range input fields are clamped
// first (year to 1..9999, month to 1..12, day to 1..month length). A result before
// 0001-01-01 or after 9999-12-31 saturates to that bound with out_of_range set. One item
// is worked at a time: after acceptance the PREP state loads the leap flag and the CLAMP
// state clamps the day, then the month step unit moves one month per cycle in the WALK
// state. The result is loaded into an output register in the DONE state, which waits
// while that register still holds an untaken result; the next item is taken once the
// block is idle again, even while the loaded result waits to be taken.
`default_nettype none
`include "date_add_subtract_days_top_defines.svh"
module date_add_subtract_days_top
	import dad_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// s_tdata from bit 0: year_in[13:0], month_in[17:14], day_in[22:18],
	// day_count[38:23], zero[39]
	input  wire logic [39:0] s_tdata,
	// s_tuser: kind
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// m_tdata from bit 0: year_out[13:0], month_out[17:14], day_out[22:18], zero[23]
	output logic [23:0]      m_tdata,
	// m_tuser: out_of_range
	output logic             m_tuser
);

	dad_state_t state_q, state_d;

	logic               kind_q;
	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic [DAY_W-1:0]   day_q;
	logic [CNT_W-1:0]   count_q;
	logic               oor_q;
	logic               leap;
	dad_step_t          step;

	logic               m_tvalid_q;
	logic [YEAR_W-1:0]  m_year_q;
	logic [MONTH_W-1:0] m_month_q;
	logic [DAY_W-1:0]   m_day_q;
	logic               m_oor_q;

	logic               accept;
	logic               load_out;
	logic [YEAR_W-1:0]  year_raw;
	logic [MONTH_W-1:0] month_raw;
	logic [YEAR_W-1:0]  year_clamp;
	logic [MONTH_W-1:0] month_clamp;
	logic [DAY_W-1:0]   len_cur;

	dad_leap u_leap (
		.clk  (clk),
		.year (year_q),
		.leap (leap)
	);

	dad_walk u_walk (
		.kind  (kind_q),
		.year  (year_q),
		.month (month_q),
		.day   (day_q),
		.count (count_q),
		.leap  (leap),
		.step  (step)
	);

	// Clamp year and month of the incoming item
	always_comb begin
		year_raw    = s_tdata[13:0];
		month_raw   = s_tdata[17:14];
		year_clamp  = (year_raw < YEAR_MIN) ? YEAR_MIN
			: (year_raw > YEAR_MAX) ? YEAR_MAX : year_raw;
		month_clamp = (month_raw < MONTH_JAN) ? MONTH_JAN
			: (month_raw > MONTH_DEC) ? MONTH_DEC : month_raw;
		len_cur     = dad_month_len(month_q, leap);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_PREP;
			ST_PREP:  state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_WALK;
			ST_WALK:  if (step.done || step.sat) state_d = ST_DONE;
			ST_DONE:  if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Handshake and output load strobes
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		accept   = s_tvalid && s_tready;
		load_out = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working date and remaining count
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= s_tuser;
			year_q  <= year_clamp;
			month_q <= month_clamp;
			day_q   <= s_tdata[22:18];
			count_q <= s_tdata[38:23];
			oor_q   <= 1'b0;
		end else if (state_q == ST_CLAMP) begin
			if (day_q < DAY_FIRST) begin
				day_q <= DAY_FIRST;
			end else if (day_q > len_cur) begin
				day_q <= len_cur;
			end
		end else if (state_q == ST_WALK) begin
			year_q  <= step.year;
			month_q <= step.month;
			day_q   <= step.day;
			count_q <= step.count;
			oor_q   <= step.sat;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_year_q  <= year_q;
			m_month_q <= month_q;
			m_day_q   <= day_q;
			m_oor_q   <= oor_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, m_day_q, m_month_q, m_year_q};
	assign m_tuser  = m_oor_q;

	// Accepting an item closes the input until the result is loaded into the output register
	`DAD_ASSERT(a_busy_after_accept, clk, arst_n, accept |=> !s_tready, "ready after accept")
	// A saturated result is one of the two bounds
	`DAD_ASSERT(a_sat_bound, clk, arst_n, (m_tvalid && m_tuser) |-> ((m_tdata[13:0] == YEAR_MIN && m_tdata[17:14] == MONTH_JAN && m_tdata[22:18] == DAY_FIRST) || (m_tdata[13:0] == YEAR_MAX && m_tdata[17:14] == MONTH_DEC && m_tdata[22:18] == DAY_LAST)), "saturated date off bound")
	// Every delivered date has year and month in range and a nonzero day
	`DAD_ASSERT(a_date_legal, clk, arst_n, m_tvalid |-> (m_tdata[17:14] != 4'd0 && m_tdata[17:14] <= MONTH_DEC && m_tdata[22:18] != 5'd0 && m_tdata[13:0] != 14'd0 && m_tdata[13:0] <= YEAR_MAX), "illegal result date")
	// Reset leaves no result pending
	`DAD_ASSERT_NR(a_reset_empty, clk, !arst_n |-> !m_tvalid, "result valid in reset")

endmodule
`default_nettype wire

// ===== hw/rtl/dad_leap.sv =====
// Registered Gregorian leap year flag for the current year.
`default_nettype none
module dad_leap
	import dad_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [YEAR_W-1:0] year,
	output logic                   leap
);

	// Reciprocal of 25 scaled by 2^17, exact for all 14-bit years
	localparam logic [12:0] RECIP_25 = 13'd5243;

	logic [26:0] prod;
	logic [9:0]  quot;
	logic [14:0] quot_x25;
	logic        div25;
	logic        leap_d;

	// Divisible by 100 means by 4 and 25; by 400 means by 16 and 25
	always_comb begin
		prod     = 27'(year) * 27'(RECIP_25);
		quot     = prod[26:17];
		quot_x25 = {1'b0, quot, 4'b0} + {2'b0, quot, 3'b0} + {5'b0, quot};
		div25    = (quot_x25[13:0] == year);
		leap_d   = (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
	end

	// Register the flag, so that it follows the year register in the cycle after
	always_ff @(posedge clk) begin
		leap <= leap_d;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/dad_walk.sv =====
// Month step unit: one shared compare/subtract that moves the date by up to one month.
`default_nettype none
module dad_walk
	import dad_pkg::*;
(
	input  wire logic               kind,
	input  wire logic [YEAR_W-1:0]  year,
	input  wire logic [MONTH_W-1:0] month,
	input  wire logic [DAY_W-1:0]   day,
	input  wire logic [CNT_W-1:0]   count,
	input  wire logic               leap,
	output dad_step_t               step
);

	logic [DAY_W-1:0]   len;
	logic [DAY_W-1:0]   room;
	logic [DAY_W:0]     span;
	logic [CNT_W:0]     diff;
	logic [MONTH_W-1:0] prev_month;

	always_comb begin
		len        = dad_month_len(month, leap);
		room       = len - day;
		// Days that cross out of this month: to the next first, or before the first
		span       = (kind == KIND_SUB) ? {1'b0, day} : ({1'b0, room} + 6'd1);
		diff       = {1'b0, count} - {{(CNT_W-DAY_W){1'b0}}, span};
		prev_month = (month == MONTH_JAN) ? MONTH_DEC : month - 4'd1;

		step.year  = year;
		step.month = month;
		step.day   = day;
		step.count = diff[CNT_W-1:0];
		step.done  = 1'b0;
		step.sat   = 1'b0;

		if (diff[CNT_W]) begin
			// Remaining count stays inside this month
			step.done  = 1'b1;
			step.count = count;
			step.day   = (kind == KIND_SUB) ? day - count[DAY_W-1:0]
				: day + count[DAY_W-1:0];
		end else if (kind == KIND_ADD) begin
			// Advance to the first of the next month
			step.day = DAY_FIRST;
			if (month == MONTH_DEC) begin
				if (year == YEAR_MAX) begin
					step.sat   = 1'b1;
					step.month = MONTH_DEC;
					step.day   = DAY_LAST;
				end else begin
					step.year  = year + 14'd1;
					step.month = MONTH_JAN;
				end
			end else begin
				step.month = month + 4'd1;
			end
		end else begin
			// Back up to the last day of the previous month
			step.month = prev_month;
			step.day   = dad_month_len(prev_month, leap);
			if (month == MONTH_JAN) begin
				if (year == YEAR_MIN) begin
					step.sat   = 1'b1;
					step.month = MONTH_JAN;
					step.day   = DAY_FIRST;
				end else begin
					step.year = year - 14'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire
